### design/fbtp_pkg.sv
// Package for the five-bit text packer.
// Holds the request types, the result bundle and the character code map.
// No dependencies.
package fbtp_pkg;

    localparam int CodeW   = 5;
    localparam int ByteW   = 8;
    localparam int PendW   = 7;
    localparam int PendCntW = 3;
    localparam int AccW    = PendW + CodeW;

    typedef struct packed {
        logic [ByteW-1:0] char_byte;
        logic             end_of_text;
    } char_req_t;

    typedef struct packed {
        logic [ByteW-1:0] packed_byte;
        logic             final_byte;
    } pack_req_t;

    typedef struct packed {
        logic [1:0] count;
        pack_req_t  first;
        pack_req_t  second;
    } pack_res_t;

    localparam logic [ByteW-1:0] ChSpace   = 8'h20;
    localparam logic [ByteW-1:0] ChComma   = 8'h2C;
    localparam logic [ByteW-1:0] ChPeriod  = 8'h2E;
    localparam logic [ByteW-1:0] ChNewline = 8'h0A;
    localparam logic [ByteW-1:0] ChTab     = 8'h09;
    localparam logic [ByteW-1:0] ChEof     = 8'hFF;

    localparam logic [CodeW-1:0] CodeSpace   = 5'd26;
    localparam logic [CodeW-1:0] CodeComma   = 5'd27;
    localparam logic [CodeW-1:0] CodePeriod  = 5'd28;
    localparam logic [CodeW-1:0] CodeNewline = 5'd29;
    localparam logic [CodeW-1:0] CodeTab     = 5'd30;
    localparam logic [CodeW-1:0] CodeEof     = 5'd31;
    localparam logic [CodeW-1:0] CodeOther   = 5'd0;

    function automatic logic [CodeW-1:0] code_of(input logic [ByteW-1:0] c);
        logic [ByteW-1:0] diff;
        begin
            diff = '0;
            if (c >= 8'h61 && c <= 8'h7A)
            begin
                diff = c - 8'h61;
                code_of = diff[CodeW-1:0];
            end
            else if (c >= 8'h41 && c <= 8'h5A)
            begin
                diff = c - 8'h41;
                code_of = diff[CodeW-1:0];
            end
            else
            begin
                case (c)
                    ChSpace:   code_of = CodeSpace;
                    ChComma:   code_of = CodeComma;
                    ChPeriod:  code_of = CodePeriod;
                    ChNewline: code_of = CodeNewline;
                    ChTab:     code_of = CodeTab;
                    ChEof:     code_of = CodeEof;
                    default:   code_of = CodeOther;
                endcase
            end
        end
    endfunction

endpackage

### design/fbtp_in_stage.sv
// Input register of the five-bit text packer.
// Depends on fbtp_pkg.
module fbtp_in_stage
    import fbtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  char_req_t char_req,
    output logic      held_valid,
    output char_req_t held_req,
    input  logic      take
);

    logic      valid_reg;
    logic      valid_next;
    char_req_t req_reg;
    logic      load;

    assign char_ready = !valid_reg || take;
    assign load       = char_valid && char_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= char_req;
        end
    end

    assign held_valid = valid_reg;
    assign held_req   = req_reg;

endmodule

### design/fbtp_pack.sv
// Code mapping and bit packing with the pending-bit state.
// Depends on fbtp_pkg.
module fbtp_pack
    import fbtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      held_valid,
    input  char_req_t held_req,
    input  logic [1:0] room,
    output logic      take,
    output pack_res_t res
);

    logic [PendW-1:0]    bits_reg;
    logic [PendW-1:0]    bits_next;
    logic [PendCntW-1:0] cnt_reg;
    logic [PendCntW-1:0] cnt_next;

    logic [ByteW-1:0]    cnt_mask;
    logic [AccW-1:0]     acc;
    logic [3:0]          total;
    logic                full;
    logic [PendCntW-1:0] rem;
    logic [ByteW-1:0]    rem_mask;
    logic [PendW-1:0]    acc_rem;
    logic [AccW-1:0]     shifted;
    logic [ByteW-1:0]    byte_full;
    logic [ByteW-1:0]    byte_flush;
    logic                last;

    always_comb
    begin
        last      = held_req.end_of_text;
        cnt_mask  = 8'((9'd1 << cnt_reg) - 9'd1);
        acc       = {bits_reg & cnt_mask[PendW-1:0], code_of(held_req.char_byte)};
        total     = {1'b0, cnt_reg} + 4'd5;
        full      = total >= 4'd8;
        shifted   = acc >> (total - 4'd8);
        byte_full = shifted[ByteW-1:0];
        rem       = full ? 3'(total - 4'd8) : total[PendCntW-1:0];
        rem_mask  = 8'((9'd1 << rem) - 9'd1);
        acc_rem   = acc[PendW-1:0] & rem_mask[PendW-1:0];
        byte_flush = 8'({1'b0, acc_rem} << (4'd8 - {1'b0, rem}));

        res = '0;
        if (full)
        begin
            res.count = 2'd1;
            res.first.packed_byte = byte_full;
            res.first.final_byte  = last && (rem == '0);
            if (last && (rem != '0))
            begin
                res.count = 2'd2;
                res.second.packed_byte = byte_flush;
                res.second.final_byte  = 1'b1;
            end
        end
        else if (last)
        begin
            res.count = 2'd1;
            res.first.packed_byte = byte_flush;
            res.first.final_byte  = 1'b1;
        end

        take = held_valid && (res.count <= room);

        if (last)
        begin
            bits_next = '0;
            cnt_next  = '0;
        end
        else
        begin
            bits_next = acc_rem;
            cnt_next  = rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### design/fbtp_out_queue.sv
// Two-entry result register queue of the five-bit text packer.
// Depends on fbtp_pkg.
module fbtp_out_queue
    import fbtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pack_res_t  res,
    output logic [1:0] room,
    output logic       pack_valid,
    input  logic       pack_ready,
    output pack_req_t  pack_req
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    pack_req_t  e0_reg;
    pack_req_t  e0_next;
    pack_req_t  e1_reg;
    pack_req_t  e1_next;
    logic       pop;
    logic [1:0] kept;
    logic [1:0] added;

    assign pop        = (count_reg != 2'd0) && pack_ready;
    assign kept       = count_reg - {1'b0, pop};
    assign room       = 2'd2 - kept;
    assign added      = push ? res.count : 2'd0;
    assign count_next = kept + added;
    assign pack_valid = count_reg != 2'd0;
    assign pack_req   = e0_reg;

    always_comb
    begin
        e0_next = pop ? e1_reg : e0_reg;
        e1_next = e1_reg;
        case (kept)
            2'd0:
            begin
                e0_next = res.first;
                e1_next = res.second;
            end
            2'd1:
            begin
                e1_next = res.first;
            end
            default:
            begin
                e1_next = e1_reg;
            end
        endcase
        if (!push)
        begin
            e0_next = pop ? e1_reg : e0_reg;
            e1_next = e1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

### design/five_bit_text_packer_core.sv
// Five-bit text packer: maps ASCII bytes to 5-bit codes, packs them MSB first.
// A request waits in the input register and its result bytes in the queue before they are offered.
// Throughput: one request per cycle if the queue has room; a flush after a full byte adds a byte.
// The result side holds two entries; the input stalls only when they cannot take a request.
// Reset (rst_n low, async) clears pending bits and count, the input valid flag and the queue count.
// Depends on fbtp_pkg, fbtp_in_stage, fbtp_pack, fbtp_out_queue.
module five_bit_text_packer_core
    import fbtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  char_req_t char_req,
    output logic      pack_valid,
    input  logic      pack_ready,
    output pack_req_t pack_req
);

    logic       held_valid;
    char_req_t  held_req;
    logic       take;
    logic [1:0] room;
    pack_res_t  res;

    fbtp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_req   (char_req),
        .held_valid (held_valid),
        .held_req   (held_req),
        .take       (take)
    );

    fbtp_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_req   (held_req),
        .room       (room),
        .take       (take),
        .res        (res)
    );

    fbtp_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .res        (res),
        .room       (room),
        .pack_valid (pack_valid),
        .pack_ready (pack_ready),
        .pack_req   (pack_req)
    );

endmodule

### design/fbtp_checker.sv
// Port-level checks for the five-bit text packer, bound to the top level.
// Depends on fbtp_pkg and five_bit_text_packer_core.
module fbtp_checker
    import fbtp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      char_valid,
    input logic      char_ready,
    input logic      pack_valid,
    input logic      pack_ready,
    input pack_req_t pack_req
);

    logic char_acc;

    assign char_acc = char_valid && char_ready;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pack_valid && !pack_ready |=> pack_valid && $stable(pack_req))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> pack_valid)
        else $error("input stalled with no result pending");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pack_valid) |-> $past(char_acc, 2))
        else $error("result appeared without a request two cycles earlier");

endmodule

bind five_bit_text_packer_core fbtp_checker u_fbtp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .pack_valid (pack_valid),
    .pack_ready (pack_ready),
    .pack_req   (pack_req)
);
